// File: rtl/sot_pkg.sv
// Shared types and constants for the turn-phase Taylor sine pipeline.
package sot_pkg;

  localparam int unsigned NUM_TERMS = 6;
  localparam int unsigned U_W       = 31;   // quarter-turn fraction, 0..2^30
  localparam int unsigned X_W       = 30;   // angle, Q1.29
  localparam int unsigned X2_W      = 2 * X_W;
  localparam int unsigned ACC_W     = 64;   // series magnitudes, Q2.62
  localparam int unsigned PROD_W    = 2 * ACC_W;

  // 2*pi in Q3.31
  localparam logic [33:0] TWO_PI_Q31 = 34'h3_243F_6A89;

  localparam logic [ACC_W-1:0] ONES = {ACC_W{1'b1}};

  // floor((2^64-1) / (2k(2k+1))) for k = 1..6
  localparam logic [ACC_W-1:0] TERM_RECIP [NUM_TERMS] = '{
    ONES / 64'(2 * 3),
    ONES / 64'(4 * 5),
    ONES / 64'(6 * 7),
    ONES / 64'(8 * 9),
    ONES / 64'(10 * 11),
    ONES / 64'(12 * 13)
  };

  // One request in flight between pipeline sections.
  typedef struct packed {
    logic             vld;
    logic [1:0]       quad;
    logic [X2_W-1:0]  x2;    // x^2, Q.58
    logic [ACC_W-1:0] sum;   // partial series sum, Q.62
    logic [ACC_W-1:0] t;     // latest term, Q.62, not yet in sum
  } sot_item_t;

endpackage

// File: rtl/sot_mul.sv
// Two-stage 64x64 multiplier built from four 32x32 partial products.
module sot_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [sot_pkg::ACC_W-1:0]  a_i,
  input  logic [sot_pkg::ACC_W-1:0]  b_i,
  output logic [sot_pkg::PROD_W-1:0] prod_o
);
  import sot_pkg::*;

  logic [ACC_W-1:0]  ll_d, lh_d, hl_d, hh_d;
  logic [ACC_W-1:0]  ll_q, lh_q, hl_q, hh_q;
  logic [PROD_W-1:0] prod_q;

  assign ll_d = a_i[31:0]  * b_i[31:0];
  assign lh_d = a_i[31:0]  * b_i[63:32];
  assign hl_d = a_i[63:32] * b_i[31:0];
  assign hh_d = a_i[63:32] * b_i[63:32];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q   <= ll_d;
      lh_q   <= lh_d;
      hl_q   <= hl_d;
      hh_q   <= hh_d;
      prod_q <= {64'b0, ll_q} + {32'b0, lh_q, 32'b0} + {32'b0, hl_q, 32'b0} + {hh_q, 64'b0};
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/sot_front.sv
// Front section: quadrant fold, angle scaling by 2*pi, and x^2.
module sot_front #(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output sot_pkg::sot_item_t    item_o
);
  import sot_pkg::*;

  localparam int unsigned MW = PHASE_BITS - 1;

  logic [1:0]            quad;
  logic [PHASE_BITS-3:0] rem;
  logic [MW-1:0]         fold;
  logic [U_W-1:0]        u_d;
  logic [64:0]           xprod;
  logic [X_W-1:0]        x_d;

  logic [2:0]            vld_q;
  logic [1:0]            quad1_q, quad2_q, quad3_q;
  logic [U_W-1:0]        u_q;
  logic [X_W-1:0]        x_q;
  logic [X2_W-1:0]       x2_q;
  logic [ACC_W-1:0]      t_q;

  assign quad = phase_i[PHASE_BITS-1 -: 2];
  assign rem  = phase_i[PHASE_BITS-3:0];
  // odd quadrants run backwards: quarter - remainder
  assign fold = quad[0] ? (MW'(1) << (PHASE_BITS - 2)) - {1'b0, rem} : {1'b0, rem};

  if (PHASE_BITS >= 32) begin : g_shr
    assign u_d = fold[MW-1 -: U_W];
  end else begin : g_shl
    assign u_d = {fold, {(32 - PHASE_BITS){1'b0}}};
  end

  assign xprod = 65'(u_q) * 65'(TWO_PI_Q31);
  assign x_d   = xprod[63:34];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad1_q <= quad;
      u_q     <= u_d;
      quad2_q <= quad1_q;
      x_q     <= x_d;
      quad3_q <= quad2_q;
      x2_q    <= x_q * x_q;
      t_q     <= {1'b0, x_q, 33'b0};
    end
  end

  assign item_o.vld  = vld_q[2];
  assign item_o.quad = quad3_q;
  assign item_o.x2   = x2_q;
  assign item_o.sum  = '0;
  assign item_o.t    = t_q;

endmodule

// File: rtl/sot_term.sv
// One series step: folds the incoming term into the sum, next term = t * x^2 / n(n+1).
module sot_term #(
  parameter int unsigned TermIdx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  sot_pkg::sot_item_t item_i,
  output sot_pkg::sot_item_t item_o
);
  import sot_pkg::*;

  localparam int unsigned      Depth = 4;
  localparam logic [ACC_W-1:0] Recip = TERM_RECIP[TermIdx[2:0]];
  localparam bit               SubIn = TermIdx[0];

  logic [ACC_W-1:0]              sum_d;
  logic [PROD_W-1:0]             prod1, prod2;
  logic [Depth-1:0]              vld_q;
  logic [Depth-1:0][1:0]         quad_q;
  logic [Depth-1:0][X2_W-1:0]    x2_q;
  logic [Depth-1:0][ACC_W-1:0]   sum_q;

  // signs alternate: the first term (x) adds, x^3/3! subtracts, ...
  assign sum_d = SubIn ? item_i.sum - item_i.t : item_i.sum + item_i.t;

  sot_mul u_mul_x2 (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .a_i    (item_i.t),
    .b_i    (ACC_W'(item_i.x2)),
    .prod_o (prod1)
  );

  // t * x^2 back to Q.62, then scaled by the constant reciprocal
  sot_mul u_mul_rcp (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .a_i    (prod1[121:58]),
    .b_i    (Recip),
    .prod_o (prod2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], item_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q <= {quad_q[Depth-2:0], item_i.quad};
      x2_q   <= {x2_q[Depth-2:0], item_i.x2};
      sum_q  <= {sum_q[Depth-2:0], sum_d};
    end
  end

  assign item_o.vld  = vld_q[Depth-1];
  assign item_o.quad = quad_q[Depth-1];
  assign item_o.x2   = x2_q[Depth-1];
  assign item_o.sum  = sum_q[Depth-1];
  assign item_o.t    = prod2[PROD_W-1 -: ACC_W];

endmodule

// File: rtl/sot_back.sv
// Back section: last term, round to output scale, saturate, apply half-turn sign.
module sot_back #(
  parameter int unsigned OUT_FRAC_BITS = 30
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  sot_pkg::sot_item_t                item_i,
  output logic                              vld_o,
  output logic signed [OUT_FRAC_BITS+1:0]   sine_o
);
  import sot_pkg::*;

  localparam int unsigned        OW     = OUT_FRAC_BITS + 2;
  localparam int unsigned        RW     = OUT_FRAC_BITS + 1;
  localparam logic [ACC_W-1:0]   RndBit = ACC_W'(1) << (61 - OUT_FRAC_BITS);
  localparam logic [RW-1:0]      One    = RW'(1) << OUT_FRAC_BITS;

  logic [ACC_W-1:0] rnd;
  logic [OW-1:0]    res_full;
  logic [RW-1:0]    res_d;

  logic [2:0]       vld_q;
  logic [1:0]       quad1_q, quad2_q;
  logic [ACC_W-1:0] sum_q;
  logic [RW-1:0]    res_q;
  logic [OW-1:0]    sine_q;

  assign rnd      = sum_q + RndBit;
  assign res_full = rnd[ACC_W-1 -: OW];
  assign res_d    = (res_full > OW'(One)) ? One : res_full[RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], item_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad1_q <= item_i.quad;
      sum_q   <= item_i.sum + item_i.t;
      quad2_q <= quad1_q;
      res_q   <= res_d;
      sine_q  <= quad2_q[1] ? OW'(0) - OW'(res_q) : OW'(res_q);
    end
  end

  assign vld_o  = vld_q[2];
  assign sine_o = $signed(sine_q);

endmodule

// File: rtl/sine_of_turns_taylor_core.sv
// Top level of the turn-phase sine pipeline (quadrant fold + 7-term odd Taylor series).
// Pipeline: the front section, six series steps, then the back section, all registered.
// Throughput: one request per cycle unless stalled; 64x64 multipliers are fully pipelined.
// Flow control: one global enable; the whole pipe holds only while a result waits stalled.
// Reset: rst_ni is asynchronous, active low, and clears every valid bit; data is not reset.
module sine_of_turns_taylor_core #(
  parameter int unsigned PHASE_BITS    = 32,
  parameter int unsigned OUT_FRAC_BITS = 30
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [PHASE_BITS-1:0]           phase_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [OUT_FRAC_BITS+1:0] sine_o
);
  import sot_pkg::*;

  logic      en;
  sot_item_t chain [NUM_TERMS+1];

  // The pipe advances unless the output register holds a result that is
  // being stalled. Bubbles simply travel with valid low, so a stall never
  // drops or repeats a request.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Fold to the first quadrant, scale to x in Q1.29, form x^2 and t0 = x.
  sot_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_valid_i),
    .phase_i (phase_i),
    .item_o  (chain[0])
  );

  // Series steps. Step k adds the term it receives into the running sum
  // (alternating sign) and produces the next odd power term, down to x^13/13!.
  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    sot_term #(
      .TermIdx (k)
    ) u_term (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .item_i (chain[k]),
      .item_o (chain[k+1])
    );
  end

  // The last term is added, then round half up, clamp at +1.0, sign by quadrant.
  sot_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .item_i (chain[NUM_TERMS]),
    .vld_o  (out_valid_o),
    .sine_o (sine_o)
  );

endmodule

// File: rtl/sot_checker.sv
// Port-level checker for the turn-phase sine pipeline, bound to the top level.
module sot_checker #(
  parameter int unsigned PHASE_BITS    = 32,
  parameter int unsigned OUT_FRAC_BITS = 30
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [PHASE_BITS-1:0]           phase_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [OUT_FRAC_BITS+1:0] sine_o
);

  localparam int unsigned      OW      = OUT_FRAC_BITS + 2;
  localparam logic signed [OW-1:0] SineOne = OW'(1) << OUT_FRAC_BITS;

  // input side is held back only by a result stuck at the output
  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall without a stalled result");

  // a stalled request keeps its phase
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(phase_i))
    else $error("stalled request changed");

  // a stalled result stays put
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sine_o))
    else $error("stalled result changed");

  // results never exceed +/-1.0
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sine_o <= SineOne) && (sine_o >= -SineOne))
    else $error("sine out of range");

endmodule

bind sine_of_turns_taylor_core sot_checker #(
  .PHASE_BITS    (PHASE_BITS),
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_sot_checker (.*);
